// ----- design/keyword_flag_scanner_top_macros.svh -----
`ifndef KEYWORD_FLAG_SCANNER_TOP_MACROS_SVH
`define KEYWORD_FLAG_SCANNER_TOP_MACROS_SVH

// same-cycle implication on clk, off while in reset
`define KFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off while in reset
`define KFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/kfs_pkg.sv -----
package kfs_pkg;

	localparam int TABLE_SIZE = 21;
	localparam int WORD_BYTES = 32;

	localparam logic [1:0] GRP_EMITTER   = 2'd0;
	localparam logic [1:0] GRP_PARTICLE  = 2'd1;
	localparam logic [1:0] GRP_SECONDARY = 2'd2;

	typedef logic [8*WORD_BYTES-1:0] kw_word_t;

	typedef struct packed {
		logic       step;
		logic       clear;
		logic [7:0] text_byte;
	} kfs_ctl_t;

	typedef struct packed {
		logic [7:0]  em;
		logic [31:0] pa;
		logic [3:0]  se;
	} kfs_flags_t;

	localparam kw_word_t KW_WORD [TABLE_SIZE] = '{
		kw_word_t'("immediate"),
		kw_word_t'("continuous"),
		kw_word_t'("dirdepend"),
		kw_word_t'("dont\137move\137with\137parent"),
		kw_word_t'("accel\137with\137parent"),
		kw_word_t'("glow"),
		kw_word_t'("clr\137change"),
		kw_word_t'("gravity"),
		kw_word_t'("collide"),
		kw_word_t'("collide\137liquid"),
		kw_word_t'("collide\137and\137die"),
		kw_word_t'("wind"),
		kw_word_t'("accelerate"),
		kw_word_t'("loop"),
		kw_word_t'("explode"),
		kw_word_t'("random\137orient"),
		kw_word_t'("vel\137stretch"),
		kw_word_t'("no\137z\137check"),
		kw_word_t'("damages"),
		kw_word_t'("hold\137last\137frame"),
		kw_word_t'("fire\137damage")
	};

	localparam logic [5:0] KW_LEN [TABLE_SIZE] = '{
		6'd9, 6'd10, 6'd9, 6'd21, 6'd17,
		6'd4, 6'd10, 6'd7, 6'd7, 6'd14, 6'd15, 6'd4, 6'd10, 6'd4, 6'd7, 6'd13,
		6'd11, 6'd10,
		6'd7, 6'd15, 6'd11
	};

	localparam logic [1:0] KW_GROUP [TABLE_SIZE] = '{
		GRP_EMITTER, GRP_EMITTER, GRP_EMITTER, GRP_EMITTER, GRP_EMITTER,
		GRP_PARTICLE, GRP_PARTICLE, GRP_PARTICLE, GRP_PARTICLE, GRP_PARTICLE,
		GRP_PARTICLE, GRP_PARTICLE, GRP_PARTICLE, GRP_PARTICLE, GRP_PARTICLE,
		GRP_PARTICLE, GRP_PARTICLE, GRP_PARTICLE,
		GRP_SECONDARY, GRP_SECONDARY, GRP_SECONDARY
	};

	localparam logic [31:0] KW_BITS [TABLE_SIZE] = '{
		32'h0000_0002, 32'h0000_0004, 32'h0000_0008, 32'h0000_0040, 32'h0000_0080,
		32'h0000_0002, 32'h0000_0004, 32'h0000_0008, 32'h0000_0010, 32'h0000_0400,
		32'h0000_0800, 32'hf000_0000, 32'h0000_0040, 32'h0000_0100, 32'h0000_0080,
		32'h0000_0200, 32'h0000_4000, 32'h0000_2000,
		32'h0000_0001, 32'h0000_0004, 32'h0000_0008
	};

	function automatic logic [7:0] kw_char(input int k, input int j);
		int pos;
		logic [7:0] ch;
		begin
			ch = 8'h00;
			if (j < int'(KW_LEN[k])) begin
				pos = 8 * (int'(KW_LEN[k]) - 1 - j);
				ch = KW_WORD[k][pos +: 8];
			end
			return ch;
		end
	endfunction

endpackage

// ----- design/kfs_cell.sv -----
module kfs_cell
	import kfs_pkg::*;
#(
	parameter int IDX     = 0,
	parameter int MAX_LEN = 21
) (
	input  logic       clk,
	input  logic       arst_n,
	input  kfs_ctl_t   ctl,
	input  kfs_flags_t acc_in,
	output kfs_flags_t acc_out
);

	localparam int          LEN  = int'(KW_LEN[IDX]);
	localparam logic [1:0]  GRP  = KW_GROUP[IDX];
	localparam logic [31:0] BITS = KW_BITS[IDX];

	logic [MAX_LEN-1:0] progress_q;
	logic [MAX_LEN-1:0] progress_nxt;
	logic               seen_q;
	logic               hit;

	always_comb begin
		progress_nxt = '0;
		hit = 1'b0;
		progress_nxt[0] = (LEN > 0) && (kw_char(IDX, 0) == ctl.text_byte);
		for (int j = 1; j < MAX_LEN; j++) begin
			progress_nxt[j] = (j < LEN) && progress_q[j-1] &&
				(kw_char(IDX, j) == ctl.text_byte);
		end
		for (int j = 0; j < MAX_LEN; j++) begin
			if (j == LEN - 1) begin
				hit = progress_nxt[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q <= '0;
			seen_q     <= 1'b0;
		end else if (ctl.clear) begin
			progress_q <= '0;
			seen_q     <= 1'b0;
		end else if (ctl.step) begin
			progress_q <= progress_nxt;
			seen_q     <= seen_q | hit;
		end
	end

	// add this keyword's bits to the running flag words
	always_comb begin
		acc_out = acc_in;
		if (seen_q) begin
			case (GRP)
				GRP_EMITTER:   acc_out.em = acc_in.em | BITS[7:0];
				GRP_PARTICLE:  acc_out.pa = acc_in.pa | BITS;
				GRP_SECONDARY: acc_out.se = acc_in.se | BITS[3:0];
				default:       acc_out = acc_in;
			endcase
		end
	end

endmodule

// ----- design/keyword_flag_scanner_top.sv -----
// Channel   Direction  Handshake                  Word
// text      in         text_valid / text_ready    text_byte, text_kind
// flags     out        flags_valid / flags_ready  kind_done, emitter_flags,
//                                                 particle_flags, secondary_flags
//
// One byte per cycle when ready; every keyword cell updates its prefix vector on acceptance.
// A zero byte loads the flag words into the output register; they show in the next cycle.
// Text bytes other than zero pass while a flag word waits; a zero byte waits for flags_ready.
// Reset clears all prefix vectors, the seen bits and the output valid.
module keyword_flag_scanner_top
	import kfs_pkg::*;
#(
	parameter int KEYWORD_COUNT   = 21,
	parameter int MAX_KEYWORD_LEN = 21
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	input  logic        text_kind,
	output logic        flags_valid,
	input  logic        flags_ready,
	output logic        kind_done,
	output logic [7:0]  emitter_flags,
	output logic [31:0] particle_flags,
	output logic [3:0]  secondary_flags
);

	localparam int ACTIVE = (KEYWORD_COUNT < TABLE_SIZE) ? KEYWORD_COUNT : TABLE_SIZE;

	logic        text_end;
	logic        accept;
	logic [7:0]  folded;
	kfs_ctl_t    ctl;
	kfs_flags_t  acc [ACTIVE+1];

	logic        flags_valid_q;
	logic        kind_q;
	logic [7:0]  emitter_q;
	logic [31:0] particle_q;
	logic [3:0]  secondary_q;

	assign text_end   = (text_byte == 8'h00);
	assign text_ready = !flags_valid_q || flags_ready || !text_end;
	assign accept     = text_valid && text_ready;
	assign folded     = (text_byte >= 8'h41 && text_byte <= 8'h5a) ?
		text_byte + 8'h20 : text_byte;

	assign ctl.step      = accept && !text_end;
	assign ctl.clear     = accept && text_end;
	assign ctl.text_byte = folded;

	assign acc[0] = '0;

	for (genvar k = 0; k < ACTIVE; k++) begin : g_cell
		kfs_cell #(
			.IDX     (k),
			.MAX_LEN (MAX_KEYWORD_LEN)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.acc_in  (acc[k]),
			.acc_out (acc[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_valid_q <= 1'b0;
		end else if (ctl.clear) begin
			flags_valid_q <= 1'b1;
		end else if (flags_ready) begin
			flags_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			kind_q      <= text_kind;
			emitter_q   <= text_kind ? 8'h00 : acc[ACTIVE].em;
			particle_q  <= text_kind ? acc[ACTIVE].pa : 32'h0;
			secondary_q <= text_kind ? acc[ACTIVE].se : 4'h0;
		end
	end

	assign flags_valid     = flags_valid_q;
	assign kind_done       = kind_q;
	assign emitter_flags   = emitter_q;
	assign particle_flags  = particle_q;
	assign secondary_flags = secondary_q;

endmodule

// ----- design/kfs_checker.sv -----
`include "keyword_flag_scanner_top_macros.svh"

module kfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        text_valid,
	input logic        text_ready,
	input logic [7:0]  text_byte,
	input logic        text_kind,
	input logic        flags_valid,
	input logic        flags_ready,
	input logic        kind_done,
	input logic [7:0]  emitter_flags,
	input logic [31:0] particle_flags,
	input logic [3:0]  secondary_flags
);

	`KFS_ASSERT_NEXT(a_flags_hold, flags_valid && !flags_ready, flags_valid && $stable(kind_done) && $stable(emitter_flags) && $stable(particle_flags) && $stable(secondary_flags), "flag word changed while stalled")

	`KFS_ASSERT_NEXT(a_end_gives_word, text_valid && text_ready && text_byte == 8'h00, flags_valid && kind_done == $past(text_kind), "text end gave no flag word")

	`KFS_ASSERT_NOW(a_emitter_only, flags_valid && !kind_done, particle_flags == 32'h0 && secondary_flags == 4'h0, "emitter text shows particle bits")

	`KFS_ASSERT_NOW(a_particle_only, flags_valid && kind_done, emitter_flags == 8'h00, "particle text shows emitter bits")

endmodule

bind keyword_flag_scanner_top kfs_checker u_kfs_checker (.*);
